// ===== src/tia_pkg.sv =====
// Shared constants, codes and types of the triangle index assembler.
package tia_pkg;

    // Storage sizes
    localparam int INDEX_DEPTH  = 4096;
    localparam int MAX_VERTICES = 4096;

    // Derived address widths
    localparam int IDX_AW    = $clog2(INDEX_DEPTH);
    localparam int VTX_W     = $clog2(MAX_VERTICES);
    localparam int MARK_W    = 16;
    localparam int MARK_ROWS = MAX_VERTICES / MARK_W;
    localparam int ROW_AW    = $clog2(MARK_ROWS);
    localparam int COL_W     = $clog2(MARK_W);

    // Field widths
    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 12;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int VI_W       = 12;
    localparam int CTR_W      = 14;
    localparam int POS_W      = CTR_W + 1;
    localparam int CNT_W      = 13;
    localparam int TOPO_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_VERTEX   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SKIPPED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_DRAW  = 2'd3;

    // Topology codes; any other code acts as a strip
    localparam logic [TOPO_W-1:0] TOPO_LIST = 2'd0;
    localparam logic [TOPO_W-1:0] TOPO_FAN  = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_INDEX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_STEP,
        S_IRD,
        S_ICHK,
        S_MRD,
        S_MUPD,
        S_EMIT
    } t_state;

endpackage

// ===== src/tia_cmd_if.sv =====
// Command channel: one command word per handshake.
interface tia_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [tia_pkg::CMD_W-1:0]   cmd;
    logic [tia_pkg::ADDR_W-1:0]  load_addr;
    logic signed [tia_pkg::VAL_W-1:0] load_value;

    modport source (output valid, output cmd, output load_addr, output load_value,
                    input ready);
    modport sink   (input valid, input cmd, input load_addr, input load_value,
                    output ready);
endinterface

// ===== src/tia_res_if.sv =====
// Result channel: one vertex or status word per handshake.
interface tia_res_if;
    logic                          valid;
    logic                          ready;
    logic [tia_pkg::STATUS_W-1:0]  status;
    logic [tia_pkg::VI_W-1:0]      vertex_index;
    logic                          first_use;
    logic                          last;

    modport source (output valid, output status, output vertex_index, output first_use,
                    output last, input ready);
    modport sink   (input valid, input status, input vertex_index, input first_use,
                    input last, output ready);
endinterface

// ===== src/triangle_index_assembler_unit.sv =====
// Top level of the triangle index assembler: sequencer, index store and sent-marks.
//
//  channel  | dir | handshake       | word
//  ---------+-----+-----------------+-------------------------------------------
//  i_cmd    | in  | valid / ready   | cmd, load_addr, load_value
//  o_res    | out | valid / ready   | status, vertex_index, first_use, last
//  i_cfg_*  | in  | write enable    | register index, data (no read-back)
//
// Load and unused commands are done in idle. A start command, and reset, run a sweep
// over the sent-mark RAM, one row per cycle through all MARK_ROWS = 256 rows, with i_cmd
// not ready. A step passes S_STEP, then S_MRD and S_MUPD per vertex on the shared mark
// read-modify-write port, after S_IRD and S_ICHK per vertex through the index store read
// port when indexed; end and no-draw steps pass S_STEP and S_EMIT, skip steps end in S_EMIT
// after the failing S_ICHK. A stalled o_res holds the sequencer before its next result
// word; i_cmd is ready again once back in idle.
module triangle_index_assembler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tia_cmd_if.sink                         i_cmd,
    tia_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [tia_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tia_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_AW  = tia_pkg::IDX_AW;
    localparam int VTX_W   = tia_pkg::VTX_W;
    localparam int ROW_AW  = tia_pkg::ROW_AW;
    localparam int COL_W   = tia_pkg::COL_W;
    localparam int MARK_W  = tia_pkg::MARK_W;
    localparam int CTR_W   = tia_pkg::CTR_W;
    localparam int POS_W   = tia_pkg::POS_W;
    localparam int CNT_W   = tia_pkg::CNT_W;
    localparam int VAL_W   = tia_pkg::VAL_W;
    localparam int ST_W    = tia_pkg::STATUS_W;
    localparam int VI_W    = tia_pkg::VI_W;
    localparam int TOPO_W  = tia_pkg::TOPO_W;

    // Configuration registers
    logic [TOPO_W-1:0] r_topology;
    logic              r_use_index;
    logic [CNT_W-1:0]  r_index_count;
    logic [CNT_W-1:0]  r_vertex_count;

    // Sequencer and draw state
    tia_pkg::t_state   r_state, n_state;
    logic              r_active, n_active;
    logic [CTR_W-1:0]  r_pos, n_pos;
    logic [CTR_W-1:0]  r_anchor, n_anchor;
    logic [CTR_W-1:0]  r_prev, n_prev;
    logic [POS_W-1:0]  r_a [3];
    logic [POS_W-1:0]  n_a [3];
    logic [VTX_W-1:0]  r_v [3];
    logic [VTX_W-1:0]  n_v [3];
    logic [1:0]        r_k, n_k;
    logic [ROW_AW-1:0] r_clr_row, n_clr_row;
    logic              r_in_range, n_in_range;
    logic [ST_W-1:0]   r_emit_status, n_emit_status;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [ST_W-1:0]   r_out_status, n_out_status;
    logic [VI_W-1:0]   r_out_vi, n_out_vi;
    logic              r_out_fu, n_out_fu;
    logic              r_out_last, n_out_last;

    // Handshake and RAM controls
    logic              cmd_accept;
    logic              out_free;
    logic              idx_we;
    logic [IDX_AW-1:0] idx_waddr;
    logic [IDX_AW-1:0] idx_raddr;
    logic [VAL_W-1:0]  idx_rdata;
    logic              mark_we;
    logic [ROW_AW-1:0] mark_waddr;
    logic [MARK_W-1:0] mark_wdata;
    logic [ROW_AW-1:0] mark_raddr;
    logic [MARK_W-1:0] mark_rdata;

    // Shared position adder and range compare
    logic [CNT_W-1:0]  icnt, vcnt, limit;
    logic [CTR_W-1:0]  pos_inc;
    logic [POS_W-1:0]  step_a0, step_a1, step_a2;
    logic [CTR_W-1:0]  step_pos;
    logic              step_end;
    logic [VAL_W-1:0]  look_val;
    logic              look_bad;
    logic [VTX_W-1:0]  cur_v;
    logic [COL_W-1:0]  cur_col;
    logic              cur_fu;

    assign cmd_accept = i_cmd.valid && i_cmd.ready;
    assign out_free   = !r_out_valid || o_res.ready;

    // Saturate the counts at the store sizes
    assign icnt  = (32'(r_index_count) > tia_pkg::INDEX_DEPTH)
                   ? CNT_W'(tia_pkg::INDEX_DEPTH) : r_index_count;
    assign vcnt  = (32'(r_vertex_count) > tia_pkg::MAX_VERTICES)
                   ? CNT_W'(tia_pkg::MAX_VERTICES) : r_vertex_count;
    assign limit = r_use_index ? icnt : vcnt;

    // Form the three positions of one triangle; a fan uses the advanced counter
    always_comb begin
        pos_inc  = r_pos + CTR_W'(1);
        step_a0  = (r_topology == tia_pkg::TOPO_FAN) ? {1'b0, r_anchor} : {1'b0, r_pos};
        step_a1  = (r_topology == tia_pkg::TOPO_FAN) ? {1'b0, pos_inc}
                                                     : {1'b0, r_pos} + POS_W'(1);
        step_a2  = step_a1 + POS_W'(1);
        step_pos = (r_topology == tia_pkg::TOPO_LIST) ? (r_pos + CTR_W'(3)) : pos_inc;
        step_end = step_a2 >= POS_W'(limit);
    end

    // Range check of a looked-up vertex index
    always_comb begin
        look_val = r_in_range ? idx_rdata : '0;
        look_bad = look_val[VAL_W-1] || (look_val[VAL_W-2:0] >= (VAL_W-1)'(vcnt));
    end

    // Sent-mark bit of the current vertex
    always_comb begin
        cur_v   = r_v[r_k];
        cur_col = cur_v[COL_W-1:0];
        cur_fu  = !mark_rdata[cur_col];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tia_pkg::S_CLEAR: begin
                if (r_clr_row == ROW_AW'(tia_pkg::MARK_ROWS - 1)) begin
                    n_state = tia_pkg::S_IDLE;
                end
            end
            tia_pkg::S_IDLE: begin
                if (cmd_accept) begin
                    if (i_cmd.cmd == tia_pkg::CMD_START) begin
                        n_state = tia_pkg::S_CLEAR;
                    end else if (i_cmd.cmd == tia_pkg::CMD_STEP) begin
                        n_state = tia_pkg::S_STEP;
                    end
                end
            end
            tia_pkg::S_STEP: begin
                if (!r_active || step_end) begin
                    n_state = tia_pkg::S_EMIT;
                end else if (r_use_index) begin
                    n_state = tia_pkg::S_IRD;
                end else begin
                    n_state = tia_pkg::S_MRD;
                end
            end
            tia_pkg::S_IRD: begin
                n_state = tia_pkg::S_ICHK;
            end
            tia_pkg::S_ICHK: begin
                if (look_bad) begin
                    n_state = tia_pkg::S_EMIT;
                end else if (r_k == 2'd2) begin
                    n_state = tia_pkg::S_MRD;
                end else begin
                    n_state = tia_pkg::S_IRD;
                end
            end
            tia_pkg::S_MRD: begin
                if (out_free) begin
                    n_state = tia_pkg::S_MUPD;
                end
            end
            tia_pkg::S_MUPD: begin
                n_state = (r_k == 2'd2) ? tia_pkg::S_IDLE : tia_pkg::S_MRD;
            end
            tia_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = tia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tia_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and output register next values
    always_comb begin
        n_active      = r_active;
        n_pos         = r_pos;
        n_anchor      = r_anchor;
        n_prev        = r_prev;
        n_a           = r_a;
        n_v           = r_v;
        n_k           = r_k;
        n_clr_row     = r_clr_row;
        n_in_range    = r_in_range;
        n_emit_status = r_emit_status;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_status  = r_out_status;
        n_out_vi      = r_out_vi;
        n_out_fu      = r_out_fu;
        n_out_last    = r_out_last;
        unique case (r_state)
            tia_pkg::S_CLEAR: begin
                n_clr_row = r_clr_row + ROW_AW'(1);
            end
            tia_pkg::S_IDLE: begin
                // Open a draw
                if (cmd_accept && i_cmd.cmd == tia_pkg::CMD_START) begin
                    n_active  = 1'b1;
                    n_pos     = '0;
                    n_anchor  = '0;
                    n_clr_row = '0;
                end
            end
            tia_pkg::S_STEP: begin
                n_k = 2'd0;
                if (!r_active) begin
                    n_emit_status = tia_pkg::ST_NO_DRAW;
                end else begin
                    n_pos  = step_pos;
                    n_prev = r_pos;
                    n_a[0] = step_a0;
                    n_a[1] = step_a1;
                    n_a[2] = step_a2;
                    if (step_end) begin
                        n_active      = 1'b0;
                        n_emit_status = tia_pkg::ST_FINISHED;
                    end else begin
                        n_v[0] = VTX_W'(step_a0);
                        n_v[1] = VTX_W'(step_a1);
                        n_v[2] = VTX_W'(step_a2);
                    end
                end
            end
            tia_pkg::S_IRD: begin
                n_in_range = 32'(r_a[r_k]) < tia_pkg::INDEX_DEPTH;
            end
            tia_pkg::S_ICHK: begin
                if (look_bad) begin
                    // Skip the triangle: advance by one, and the anchor on the first vertex
                    n_pos         = r_prev + CTR_W'(1);
                    n_emit_status = tia_pkg::ST_SKIPPED;
                    if (r_k == 2'd0) begin
                        n_anchor = r_anchor + CTR_W'(1);
                    end
                end else begin
                    n_v[r_k] = VTX_W'(look_val);
                    n_k      = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end
            end
            tia_pkg::S_MRD: begin
            end
            tia_pkg::S_MUPD: begin
                // Send one vertex word
                n_out_valid  = 1'b1;
                n_out_status = tia_pkg::ST_VERTEX;
                n_out_vi     = VI_W'(cur_v);
                n_out_fu     = cur_fu;
                n_out_last   = (r_k == 2'd2);
                n_k          = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            tia_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_emit_status;
                    n_out_vi     = '0;
                    n_out_fu     = 1'b0;
                    n_out_last   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // RAM controls and handshake outputs
    always_comb begin
        i_cmd.ready = (r_state == tia_pkg::S_IDLE);
        idx_we      = cmd_accept && (i_cmd.cmd == tia_pkg::CMD_LOAD)
                      && (32'(i_cmd.load_addr) < tia_pkg::INDEX_DEPTH);
        idx_waddr   = IDX_AW'(i_cmd.load_addr);
        idx_raddr   = IDX_AW'(r_a[r_k]);
        mark_raddr  = cur_v[VTX_W-1:COL_W];
        mark_we     = 1'b0;
        mark_waddr  = cur_v[VTX_W-1:COL_W];
        mark_wdata  = mark_rdata | (MARK_W'(1) << cur_col);
        unique case (r_state)
            tia_pkg::S_CLEAR: begin
                mark_we    = 1'b1;
                mark_waddr = r_clr_row;
                mark_wdata = '0;
            end
            tia_pkg::S_MUPD: begin
                mark_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.vertex_index = r_out_vi;
    assign o_res.first_use    = r_out_fu;
    assign o_res.last         = r_out_last;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tia_pkg::S_CLEAR;
            r_active       <= 1'b0;
            r_pos          <= '0;
            r_anchor       <= '0;
            r_k            <= '0;
            r_clr_row      <= '0;
            r_out_valid    <= 1'b0;
            r_topology     <= '0;
            r_use_index    <= 1'b0;
            r_index_count  <= '0;
            r_vertex_count <= '0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_pos       <= n_pos;
            r_anchor    <= n_anchor;
            r_k         <= n_k;
            r_clr_row   <= n_clr_row;
            r_out_valid <= n_out_valid;
            // Take configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tia_pkg::CFG_TOPOLOGY:     r_topology     <= TOPO_W'(i_cfg_data);
                    tia_pkg::CFG_USE_INDEX:    r_use_index    <= i_cfg_data[0];
                    tia_pkg::CFG_INDEX_COUNT:  r_index_count  <= CNT_W'(i_cfg_data);
                    tia_pkg::CFG_VERTEX_COUNT: r_vertex_count <= CNT_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prev        <= n_prev;
        r_a           <= n_a;
        r_v           <= n_v;
        r_in_range    <= n_in_range;
        r_emit_status <= n_emit_status;
        r_out_status  <= n_out_status;
        r_out_vi      <= n_out_vi;
        r_out_fu      <= n_out_fu;
        r_out_last    <= n_out_last;
    end

    // Index store
    tia_ram #(
        .WIDTH (VAL_W),
        .DEPTH (tia_pkg::INDEX_DEPTH)
    ) u_index_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (idx_waddr),
        .i_wdata (VAL_W'(i_cmd.load_value)),
        .i_raddr (idx_raddr),
        .o_rdata (idx_rdata)
    );

    // Sent-marks, packed into rows
    tia_ram #(
        .WIDTH (MARK_W),
        .DEPTH (tia_pkg::MARK_ROWS)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

endmodule

// ===== src/tia_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register one read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the triangle index assembler: command words in, vertex words checked.
`timescale 1ns / 1ps

module testbench;

    // Sizes and widths taken from the package
    localparam int INDEX_DEPTH  = tia_pkg::INDEX_DEPTH;
    localparam int MAX_VERTICES = tia_pkg::MAX_VERTICES;
    localparam int CMD_W        = tia_pkg::CMD_W;
    localparam int ADDR_W       = tia_pkg::ADDR_W;
    localparam int VAL_W        = tia_pkg::VAL_W;
    localparam int STATUS_W     = tia_pkg::STATUS_W;
    localparam int VI_W         = tia_pkg::VI_W;
    localparam int CTR_W        = tia_pkg::CTR_W;
    localparam int CNT_W        = tia_pkg::CNT_W;
    localparam int TOPO_W       = tia_pkg::TOPO_W;
    localparam int CFG_IDX_W    = tia_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = tia_pkg::CFG_DATA_W;

    // Codes the package leaves unnamed
    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [TOPO_W-1:0] TOPO_STRIP = 2'd2;
    localparam logic [TOPO_W-1:0] TOPO_SPARE = 2'd3;

    // Two copies of the block state: one runs ahead while words are queued, one on acceptance
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    localparam int RANDOM_ITEMS  = 350;
    localparam int MAX_GAP       = 13;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 320;
    localparam int LIMIT_CYCLES  = 1000000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  value;
    } t_cmd_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VI_W-1:0]     vertex;
        logic                first;
        logic                last;
    } t_res_word;

    // Bench-side drivers, each with a known value from time zero
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  cmd_valid   = 1'b0;
    logic [CMD_W-1:0]      cmd_code    = '0;
    logic [ADDR_W-1:0]     cmd_addr    = '0;
    logic [VAL_W-1:0]      cmd_value   = '0;
    logic                  res_ready   = 1'b0;
    bit                    hold_req    = 1'b0;
    bit                    hold_seen   = 1'b0;
    int                    hold_left   = 0;
    int                    src_gap_max = 0;
    int                    snk_gap_max = 0;
    int                    send_gap    = 0;
    int                    take_gap    = 0;
    int                    error_count = 0;
    int                    fed_count   = 0;
    int                    cycle_count = 0;
    t_cmd_word             send_word;

    t_cmd_word cmd_backlog [$];
    t_res_word due_words [$];

    // Predicted block state, per copy
    logic [VAL_W-1:0]  store_q  [2][INDEX_DEPTH];
    bit                sent_q   [2][MAX_VERTICES];
    logic [CTR_W-1:0]  pos_q    [2];
    logic [CTR_W-1:0]  anchor_q [2];
    bit                active_q [2];
    logic [TOPO_W-1:0] topo_q   [2];
    bit                indexed_q[2];
    logic [CNT_W-1:0]  icnt_q   [2];
    logic [CNT_W-1:0]  vcnt_q   [2];
    bit                loaded   [INDEX_DEPTH];

    tia_cmd_if cmd_bus ();
    tia_res_if res_bus ();

    assign cmd_bus.valid      = cmd_valid;
    assign cmd_bus.cmd        = cmd_code;
    assign cmd_bus.load_addr  = cmd_addr;
    assign cmd_bus.load_value = cmd_value;
    assign res_bus.ready      = res_ready;

    triangle_index_assembler_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_bus),
        .o_res       (res_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int sat_count(input logic [CNT_W-1:0] c, input int cap);
        return (int'(c) > cap) ? cap : int'(c);
    endfunction

    // Three corner positions of the next triangle and the counter after the step
    function automatic void tri_corners(input int s, output int a0, output int a1,
                                        output int a2, output logic [CTR_W-1:0] nxt);
        int p;
        p = int'(pos_q[s]);
        case (topo_q[s])
            tia_pkg::TOPO_LIST: begin
                a0 = p; a1 = p + 1; a2 = p + 2;
                nxt = CTR_W'(p + 3);
            end
            tia_pkg::TOPO_FAN: begin
                nxt = CTR_W'(p + 1);
                a0 = int'(anchor_q[s]); a1 = int'(nxt); a2 = int'(nxt) + 1;
            end
            default: begin
                a0 = p; a1 = p + 1; a2 = p + 2;
                nxt = CTR_W'(p + 1);
            end
        endcase
    endfunction

    function automatic void note_result(input int s, input logic [STATUS_W-1:0] st,
                                        input logic [VI_W-1:0] vi, input logic fu,
                                        input logic lst);
        t_res_word r;
        r.status = st; r.vertex = vi; r.first = fu; r.last = lst;
        if (s == LIVE) due_words.insert(due_words.size(), r);
    endfunction

    // Apply one command word to a state copy; the live copy also yields expected words
    function automatic void assemble_triangle(input int s, input t_cmd_word w);
        int               a[3];
        longint           v[3];
        int               icnt;
        int               vcnt;
        int               k;
        int               vi;
        logic             fu;
        logic [CTR_W-1:0] prev;
        logic [CTR_W-1:0] nxt;
        if (w.cmd == tia_pkg::CMD_LOAD) begin
            store_q[s][w.addr] = w.value;
            return;
        end
        if (w.cmd == tia_pkg::CMD_START) begin
            for (k = 0; k < MAX_VERTICES; k++) sent_q[s][k] = 1'b0;
            pos_q[s] = '0;
            anchor_q[s] = '0;
            active_q[s] = 1'b1;
            return;
        end
        if (w.cmd != tia_pkg::CMD_STEP) return;
        if (!active_q[s]) begin
            note_result(s, tia_pkg::ST_NO_DRAW, '0, 1'b0, 1'b1);
            return;
        end
        icnt = sat_count(icnt_q[s], INDEX_DEPTH);
        vcnt = sat_count(vcnt_q[s], MAX_VERTICES);
        prev = pos_q[s];
        tri_corners(s, a[0], a[1], a[2], nxt);
        pos_q[s] = nxt;
        if (indexed_q[s]) begin
            if (a[2] >= icnt) begin
                active_q[s] = 1'b0;
                note_result(s, tia_pkg::ST_FINISHED, '0, 1'b0, 1'b1);
                return;
            end
            for (k = 0; k < 3; k++) v[k] = longint'($signed(store_q[s][a[k]]));
            // Drop the triangle at the first out-of-range vertex
            for (k = 0; k < 3; k++) begin
                if (v[k] < 0 || v[k] >= vcnt) begin
                    pos_q[s] = prev + 1'b1;
                    if (k == 0) anchor_q[s] = anchor_q[s] + 1'b1;
                    note_result(s, tia_pkg::ST_SKIPPED, '0, 1'b0, 1'b1);
                    return;
                end
            end
        end else begin
            if (a[2] >= vcnt) begin
                active_q[s] = 1'b0;
                note_result(s, tia_pkg::ST_FINISHED, '0, 1'b0, 1'b1);
                return;
            end
            for (k = 0; k < 3; k++) v[k] = a[k];
        end
        for (k = 0; k < 3; k++) begin
            vi = int'(v[k]);
            fu = !sent_q[s][vi];
            sent_q[s][vi] = 1'b1;
            note_result(s, tia_pkg::ST_VERTEX, VI_W'(vi), fu, k == 2);
        end
    endfunction

    function automatic t_cmd_word word_of(input logic [CMD_W-1:0] c,
                                          input logic [ADDR_W-1:0] a,
                                          input logic [VAL_W-1:0] v);
        t_cmd_word w;
        w.cmd = c; w.addr = a; w.value = v;
        return w;
    endfunction

    function automatic t_cmd_word rand_word(input logic [CMD_W-1:0] c);
        return word_of(c, ADDR_W'($urandom), $urandom);
    endfunction

    function automatic void queue_word(input t_cmd_word w);
        cmd_backlog.insert(cmd_backlog.size(), w);
        if (w.cmd == tia_pkg::CMD_LOAD) loaded[w.addr] = 1'b1;
        if (w.cmd != CMD_UNUSED) fed_count++;
        assemble_triangle(PLAN, w);
    endfunction

    // Index value: mostly a valid vertex, sometimes negative or past the buffer
    function automatic logic [VAL_W-1:0] pick_value();
        int vc;
        int roll;
        vc = sat_count(vcnt_q[PLAN], MAX_VERTICES);
        roll = $urandom_range(0, 99);
        if (roll < 78 && vc > 0) return VAL_W'($urandom_range(0, vc - 1));
        if (roll < 86) return VAL_W'(-int'($urandom_range(1, 70000)));
        if (roll < 94) return VAL_W'(vc + int'($urandom_range(0, 9000)));
        return $urandom;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 18) return CNT_W'(4096);
        if (roll < 26) return '1;
        if (roll < 32) return CNT_W'($urandom);
        return CNT_W'($urandom_range(1, 40));
    endfunction

    // Queue a step, first loading any index entry it reads that was never written
    function automatic void queue_step();
        int               a[3];
        int               k;
        logic [CTR_W-1:0] nxt;
        if (indexed_q[PLAN] && active_q[PLAN]) begin
            tri_corners(PLAN, a[0], a[1], a[2], nxt);
            if (a[2] < sat_count(icnt_q[PLAN], INDEX_DEPTH)) begin
                for (k = 0; k < 3; k++)
                    if (!loaded[a[k]])
                        queue_word(word_of(tia_pkg::CMD_LOAD, ADDR_W'(a[k]), pick_value()));
            end
        end
        queue_word(rand_word(tia_pkg::CMD_STEP));
    endfunction

    task automatic set_config(input logic [TOPO_W-1:0] topo, input logic use_idx,
                              input logic [CNT_W-1:0] icnt, input logic [CNT_W-1:0] vcnt);
        int s;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= tia_pkg::CFG_TOPOLOGY;
        cfg_data  <= CFG_DATA_W'(topo);
        @(posedge clk);
        cfg_index <= tia_pkg::CFG_USE_INDEX;
        cfg_data  <= CFG_DATA_W'(use_idx);
        @(posedge clk);
        cfg_index <= tia_pkg::CFG_INDEX_COUNT;
        cfg_data  <= CFG_DATA_W'(icnt);
        @(posedge clk);
        cfg_index <= tia_pkg::CFG_VERTEX_COUNT;
        cfg_data  <= CFG_DATA_W'(vcnt);
        @(posedge clk);
        cfg_we <= 1'b0;
        for (s = 0; s < 2; s++) begin
            topo_q[s]    = topo;
            indexed_q[s] = use_idx;
            icnt_q[s]    = icnt;
            vcnt_q[s]    = vcnt;
        end
    endtask

    // Wait until every word is sent and answered, then let a start sweep run out
    task automatic wait_idle();
        do @(posedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || due_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Stimulus: directed draws first, then random phases with fresh settings
    initial begin
        int phase;
        int nsteps;
        int roll;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // No draw, unused command, empty vertex buffer
        set_config(tia_pkg::TOPO_LIST, 1'b0, '0, '0);
        queue_word(rand_word(tia_pkg::CMD_STEP));
        queue_word(rand_word(CMD_UNUSED));
        queue_word(rand_word(tia_pkg::CMD_START));
        queue_word(rand_word(tia_pkg::CMD_STEP));
        queue_word(rand_word(tia_pkg::CMD_STEP));
        wait_idle();

        // Direct list, fan and strip, the spare topology code acting as a strip
        set_config(tia_pkg::TOPO_LIST, 1'b0, '0, CNT_W'(3));
        queue_word(rand_word(tia_pkg::CMD_START));
        repeat (2) queue_word(rand_word(tia_pkg::CMD_STEP));
        wait_idle();
        set_config(tia_pkg::TOPO_FAN, 1'b0, '0, CNT_W'(4));
        queue_word(rand_word(tia_pkg::CMD_START));
        repeat (3) queue_word(rand_word(tia_pkg::CMD_STEP));
        wait_idle();
        set_config(TOPO_STRIP, 1'b0, '0, CNT_W'(4));
        queue_word(rand_word(tia_pkg::CMD_START));
        repeat (3) queue_word(rand_word(tia_pkg::CMD_STEP));
        wait_idle();
        set_config(TOPO_SPARE, 1'b0, '0, CNT_W'(4));
        queue_word(rand_word(tia_pkg::CMD_START));
        repeat (3) queue_word(rand_word(tia_pkg::CMD_STEP));
        wait_idle();

        // Indexed fan: negative anchor, top vertex, out-of-range vertices, oversized count
        set_config(tia_pkg::TOPO_FAN, 1'b1, CNT_W'(5), '1);
        queue_word(word_of(tia_pkg::CMD_LOAD, ADDR_W'(0), 32'h8000_0000));
        queue_word(word_of(tia_pkg::CMD_LOAD, ADDR_W'(1), 32'd2));
        queue_word(word_of(tia_pkg::CMD_LOAD, ADDR_W'(2), 32'd4095));
        queue_word(word_of(tia_pkg::CMD_LOAD, ADDR_W'(3), 32'd4096));
        queue_word(word_of(tia_pkg::CMD_LOAD, ADDR_W'(4), 32'h7FFF_FFFF));
        queue_word(word_of(tia_pkg::CMD_LOAD, '1, '1));
        queue_word(rand_word(tia_pkg::CMD_START));
        repeat (4) queue_word(rand_word(tia_pkg::CMD_STEP));

        // Random phases: draws with random content, some noise, sometimes a carried draw
        fed_count = 0;
        phase = 0;
        while (fed_count < RANDOM_ITEMS) begin
            wait_idle();
            set_config(TOPO_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       pick_count(), pick_count());
            src_gap_max <= ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            snk_gap_max <= ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            if (phase == 2 || phase == 9) hold_req <= !hold_req;
            if ($urandom_range(0, 4) != 0) queue_word(rand_word(tia_pkg::CMD_START));
            nsteps = $urandom_range(4, 24);
            repeat (nsteps) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) queue_word(rand_word(tia_pkg::CMD_LOAD));
                else if (roll < 9) queue_word(rand_word(CMD_UNUSED));
                else if (roll < 11) queue_word(rand_word(tia_pkg::CMD_START));
                queue_step();
            end
            phase++;
        end

        wait_idle();
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Command driver: hold a word until taken, then idle for a drawn number of cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (cmd_valid && cmd_bus.ready) begin
                assemble_triangle(LIVE, send_word);
                send_gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
            end
            if (!cmd_valid || cmd_bus.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    send_word = cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                    cmd_code  <= send_word.cmd;
                    cmd_addr  <= send_word.addr;
                    cmd_value <= send_word.value;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Long result hold-off, restarted whenever the stimulus flips its request
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compare each word with the oldest prediction, then stall at random
    always @(posedge clk) begin
        t_res_word want;
        if (!rst_n) begin
            res_ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (res_bus.valid && res_ready) begin
                if (due_words.size() == 0) begin
                    flag_error($sformatf("unexpected word status=%0d vertex=%0d",
                                         res_bus.status, res_bus.vertex_index));
                end else begin
                    want = due_words.pop_front();
                    if (res_bus.status !== want.status)
                        flag_error($sformatf("status %0d, want %0d",
                                             res_bus.status, want.status));
                    if (res_bus.vertex_index !== want.vertex)
                        flag_error($sformatf("vertex_index %0d, want %0d",
                                             res_bus.vertex_index, want.vertex));
                    if (res_bus.first_use !== want.first)
                        flag_error($sformatf("first_use %0b, want %0b (vertex %0d)",
                                             res_bus.first_use, want.first, want.vertex));
                    if (res_bus.last !== want.last)
                        flag_error($sformatf("last %0b, want %0b",
                                             res_bus.last, want.last));
                end
                take_gap = (snk_gap_max == 0) ? 0 : $urandom_range(0, snk_gap_max);
            end
            if (hold_left != 0) begin
                res_ready <= 1'b0;
            end else if (take_gap != 0) begin
                take_gap--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ===== files.f =====
src/tia_pkg.sv
src/tia_cmd_if.sv
src/tia_res_if.sv
src/tia_ram.sv
src/triangle_index_assembler_unit.sv
bench/testbench.sv
